@@ rtl/atcs_pkg.sv @@
// ----------------------------------------------------------------------------
// atcs_pkg
// Types, codes and small helpers shared by the alarm table blocks.
// ----------------------------------------------------------------------------
package atcs_pkg;

   // command codes on the request channel
   localparam logic [2:0] CMD_RAISE   = 3'd0;
   localparam logic [2:0] CMD_CLEAR   = 3'd1;
   localparam logic [2:0] CMD_NOTE    = 3'd2;
   localparam logic [2:0] CMD_ACK     = 3'd3;
   localparam logic [2:0] CMD_ACK_ALL = 3'd4;
   localparam logic [2:0] CMD_SHELVE  = 3'd5;

   // response status codes
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [1:0] ST_FULL      = 2'd2;

   // csr register indexes
   localparam logic [1:0] CSR_CHATTER_LIMIT  = 2'd0;
   localparam logic [1:0] CSR_CHATTER_WINDOW = 2'd1;
   localparam logic [1:0] CSR_SHELF_TIME     = 2'd2;
   localparam logic [1:0] CSR_HIGH_SEVERITY  = 2'd3;

   typedef enum logic [2:0] {
      OP_RAISE,
      OP_CLEAR,
      OP_NOTE,
      OP_ACK,
      OP_ACK_ALL,
      OP_SHELVE,
      OP_NONE
   } op_type;

   typedef struct packed {
      logic [2:0]  cmd;
      logic [15:0] alarm_key;
      logic [31:0] now;
      logic [2:0]  severity;
      logic [7:0]  sink_mask;
      logic [15:0] shelve_seconds;
   } req_type;

   typedef struct packed {
      logic [1:0]        status;
      logic              notify;
      logic [5:0]        newly_acked;
      logic [15:0]       raise_total;
      logic [5:0]        unacked_total;
      logic [5:0]        active_total;
      logic signed [3:0] worst_unacked;
      logic [31:0]       generation;
   } rsp_type;

   typedef struct packed {
      op_type  op;
      req_type req;
   } work_type;

   typedef struct packed {
      logic [7:0]  chatter_limit;
      logic [15:0] chatter_window;
      logic [15:0] shelf_time;
      logic [2:0]  high_severity;
   } cfg_type;

   typedef struct packed {
      logic retired;
      logic notice;
      logic acked;
      logic active;
      logic used;
   } flags_type;

   // now + b, saturating at all ones
   function automatic logic [31:0] add_sat(logic [31:0] a, logic [15:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {17'b0, b};
      return s[32] ? 32'hFFFF_FFFF : s[31:0];
   endfunction

   // signed elapsed time strictly above lim; time running backwards never counts
   function automatic logic later(logic [31:0] t_now, logic [31:0] t_then, logic [16:0] lim);
      logic signed [33:0] d;
      d = $signed({2'b00, t_now}) - $signed({2'b00, t_then});
      return d > $signed({17'b0, lim});
   endfunction

endpackage

@@ rtl/atcs_front.sv @@
// ----------------------------------------------------------------------------
// atcs_front
// Accepts requests, decodes the command and holds them in a two-deep queue.
// ----------------------------------------------------------------------------
module atcs_front import atcs_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  req_type  req_data,
   output logic     q_valid,
   input  logic     q_ready,
   output work_type q_item
);

   work_type   slots_ff [2];
   logic       wp_ff, wp_in;
   logic       rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push, pop;
   work_type   dec;

   always_comb begin
      dec.req = req_data;
      unique case (req_data.cmd)
         CMD_RAISE:   dec.op = OP_RAISE;
         CMD_CLEAR:   dec.op = OP_CLEAR;
         CMD_NOTE:    dec.op = OP_NOTE;
         CMD_ACK:     dec.op = OP_ACK;
         CMD_ACK_ALL: dec.op = OP_ACK_ALL;
         CMD_SHELVE:  dec.op = OP_SHELVE;
         default:     dec.op = OP_NONE;
      endcase
   end

   assign req_ready = (cnt_ff != 2'd2);
   assign q_valid   = (cnt_ff != 2'd0);
   assign q_item    = slots_ff[rp_ff];
   assign push      = req_valid && req_ready;
   assign pop       = q_valid && q_ready;

   always_comb begin
      wp_in  = push ? ~wp_ff : wp_ff;
      rp_in  = pop ? ~rp_ff : rp_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) slots_ff[wp_ff] <= dec;
   end

endmodule

@@ rtl/atcs_back.sv @@
// ----------------------------------------------------------------------------
// atcs_back
// Table storage and the command sequencer: lookup scan, entry update,
// ack-all sweep and totals scan, then a registered response.
// ----------------------------------------------------------------------------
module atcs_back import atcs_pkg::*; #(
   parameter int TABLE_DEPTH = 32
) (
   input  logic     clock,
   input  logic     reset,
   input  cfg_type  cfg,
   input  logic     q_valid,
   output logic     q_ready,
   input  work_type q_item,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   output rsp_type  rsp_data
);

   localparam int IW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam logic [CW-1:0] SCAN_END = CW'(TABLE_DEPTH);

   typedef enum logic [2:0] {
      S_IDLE, S_FIND, S_READ, S_APPLY, S_ACK_ALL, S_TOTAL, S_DONE
   } state_type;

   // entry stores
   logic [15:0] key_mem     [TABLE_DEPTH];
   logic [2:0]  sev_mem     [TABLE_DEPTH];
   logic [7:0]  sinks_mem   [TABLE_DEPTH];
   logic [31:0] raised_mem  [TABLE_DEPTH];
   logic [31:0] cleared_mem [TABLE_DEPTH];
   logic [15:0] act_mem     [TABLE_DEPTH];
   logic [31:0] wb_mem      [TABLE_DEPTH];
   logic [7:0]  wc_mem      [TABLE_DEPTH];
   logic [31:0] silent_mem  [TABLE_DEPTH];

   logic [15:0] rd_key_ff;
   logic [2:0]  rd_sev_ff;
   logic [31:0] rd_raised_ff, rd_cleared_ff, rd_wb_ff, rd_silent_ff;
   logic [15:0] rd_act_ff;
   logic [7:0]  rd_wc_ff;

   flags_type flags_ff [TABLE_DEPTH];

   state_type         state_ff, state_in;
   work_type          cur_ff, cur_in;
   logic [CW-1:0]     scan_ff, scan_in;
   logic              pipe_vld_ff, pipe_vld_in;
   logic [IW-1:0]     pipe_idx_ff, pipe_idx_in;
   logic              hit_ff, hit_in, free_ff, free_in, ret_ff, ret_in, old_ff, old_in;
   logic [IW-1:0]     hit_idx_ff, hit_idx_in, free_idx_ff, free_idx_in;
   logic [IW-1:0]     ret_idx_ff, ret_idx_in, old_idx_ff, old_idx_in;
   logic [31:0]       old_time_ff, old_time_in;
   logic [IW-1:0]     slot_ff, slot_in;
   logic [CW-1:0]     nacked_ff, nacked_in, unacked_ff, unacked_in, active_ff, active_in;
   logic signed [3:0] worst_ff, worst_in;
   logic [31:0]       gen_ff, gen_in;
   logic [1:0]        status_ff, status_in;
   logic              notify_ff, notify_in;
   logic [15:0]       rtotal_ff, rtotal_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   // memory ports
   logic [IW-1:0] ra, wa;
   logic          we_all, we_clr, we_sil;
   logic [15:0]   wd_key, wd_act;
   logic [2:0]    wd_sev;
   logic [7:0]    wd_sinks, wd_wc;
   logic [31:0]   wd_raised, wd_cleared, wd_wb, wd_silent;
   logic          flags_we;
   logic [IW-1:0] flags_wa;
   flags_type     flags_wd;

   always_ff @(posedge clock) begin
      if (we_all) begin
         key_mem[wa]    <= wd_key;
         sev_mem[wa]    <= wd_sev;
         sinks_mem[wa]  <= wd_sinks;
         raised_mem[wa] <= wd_raised;
         act_mem[wa]    <= wd_act;
         wb_mem[wa]     <= wd_wb;
         wc_mem[wa]     <= wd_wc;
      end
      if (we_all || we_clr) cleared_mem[wa] <= wd_cleared;
      if (we_all || we_sil) silent_mem[wa]  <= wd_silent;
      rd_key_ff     <= key_mem[ra];
      rd_sev_ff     <= sev_mem[ra];
      rd_raised_ff  <= raised_mem[ra];
      rd_cleared_ff <= cleared_mem[ra];
      rd_act_ff     <= act_mem[ra];
      rd_wb_ff      <= wb_mem[ra];
      rd_wc_ff      <= wc_mem[ra];
      rd_silent_ff  <= silent_mem[ra];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      flags_type     pf, fe, nf;
      logic          reap, found, newly;
      logic [IW-1:0] pick;
      logic [15:0]   b_act;
      logic [31:0]   b_wb, b_sil, b_clr, b_raised;
      logic [7:0]    b_wc;

      state_in     = state_ff;
      cur_in       = cur_ff;
      scan_in      = scan_ff;
      pipe_vld_in  = 1'b0;
      pipe_idx_in  = pipe_idx_ff;
      hit_in       = hit_ff;
      hit_idx_in   = hit_idx_ff;
      free_in      = free_ff;
      free_idx_in  = free_idx_ff;
      ret_in       = ret_ff;
      ret_idx_in   = ret_idx_ff;
      old_in       = old_ff;
      old_idx_in   = old_idx_ff;
      old_time_in  = old_time_ff;
      slot_in      = slot_ff;
      nacked_in    = nacked_ff;
      unacked_in   = unacked_ff;
      active_in    = active_ff;
      worst_in     = worst_ff;
      gen_in       = gen_ff;
      status_in    = status_ff;
      notify_in    = notify_ff;
      rtotal_in    = rtotal_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      q_ready      = 1'b0;
      ra           = '0;
      wa           = '0;
      we_all       = 1'b0;
      we_clr       = 1'b0;
      we_sil       = 1'b0;
      wd_key       = rd_key_ff;
      wd_sev       = rd_sev_ff;
      wd_sinks     = cur_ff.req.sink_mask;
      wd_raised    = rd_raised_ff;
      wd_cleared   = cur_ff.req.now;
      wd_act       = rd_act_ff;
      wd_wb        = rd_wb_ff;
      wd_wc        = rd_wc_ff;
      wd_silent    = rd_silent_ff;
      flags_we     = 1'b0;
      flags_wa     = pipe_idx_ff;
      flags_wd     = '0;
      reap         = 1'b0;
      found        = 1'b0;
      newly        = 1'b0;
      pick         = '0;
      b_act        = '0;
      b_wb         = '0;
      b_sil        = '0;
      b_clr        = '0;
      b_raised     = '0;
      b_wc         = '0;
      pf           = flags_ff[pipe_idx_ff];
      fe           = pf;
      nf           = flags_ff[slot_ff];

      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;

      // shared scan issue: one read per cycle, processed in the following cycle
      if ((state_ff == S_FIND || state_ff == S_ACK_ALL || state_ff == S_TOTAL) &&
          scan_ff != SCAN_END) begin
         ra          = scan_ff[IW-1:0];
         pipe_vld_in = 1'b1;
         pipe_idx_in = scan_ff[IW-1:0];
         scan_in     = scan_ff + CW'(1);
      end

      unique case (state_ff)
         S_IDLE: begin
            q_ready = 1'b1;
            if (q_valid) begin
               cur_in     = q_item;
               scan_in    = '0;
               hit_in     = 1'b0;
               free_in    = 1'b0;
               ret_in     = 1'b0;
               old_in     = 1'b0;
               nacked_in  = '0;
               unacked_in = '0;
               active_in  = '0;
               worst_in   = -4'sd1;
               status_in  = ST_OK;
               notify_in  = 1'b0;
               rtotal_in  = '0;
               unique case (q_item.op)
                  OP_ACK_ALL: state_in = S_ACK_ALL;
                  OP_NONE:    state_in = S_TOTAL;
                  default:    state_in = S_FIND;
               endcase
            end
         end

         S_FIND: begin
            if (pipe_vld_ff) begin
               // raise reaps stale retired entries as the scan passes them
               reap = (cur_ff.op == OP_RAISE) && pf.used && pf.retired &&
                      later(cur_ff.req.now, rd_cleared_ff, {cfg.chatter_window, 1'b0}) &&
                      (rd_silent_ff < cur_ff.req.now);
               if (reap) begin
                  flags_we = 1'b1;
                  fe       = '0;
               end
               if (!hit_ff && fe.used && rd_key_ff == cur_ff.req.alarm_key) begin
                  hit_in     = 1'b1;
                  hit_idx_in = pipe_idx_ff;
               end
               if (!free_ff && !fe.used) begin
                  free_in     = 1'b1;
                  free_idx_in = pipe_idx_ff;
               end
               if (!ret_ff && fe.retired) begin
                  ret_in     = 1'b1;
                  ret_idx_in = pipe_idx_ff;
               end
               if (!fe.active && fe.acked && (!old_ff || rd_raised_ff < old_time_ff)) begin
                  old_in      = 1'b1;
                  old_idx_in  = pipe_idx_ff;
                  old_time_in = rd_raised_ff;
               end
            end else if (scan_ff == SCAN_END) begin
               if (hit_ff) begin
                  found = 1'b1;
                  pick  = hit_idx_ff;
               end else if (cur_ff.op == OP_RAISE || cur_ff.op == OP_NOTE) begin
                  found = free_ff || ret_ff || old_ff;
                  pick  = free_ff ? free_idx_ff : ret_ff ? ret_idx_ff : old_idx_ff;
               end
               slot_in = pick;
               if (found) state_in = S_READ;
               else begin
                  status_in = (cur_ff.op == OP_RAISE || cur_ff.op == OP_NOTE) ?
                              ST_FULL : ST_NOT_FOUND;
                  scan_in   = '0;
                  state_in  = S_TOTAL;
               end
            end
         end

         S_READ: begin
            ra       = slot_ff;
            state_in = S_APPLY;
         end

         S_APPLY: begin
            wa       = slot_ff;
            flags_wa = slot_ff;
            case (cur_ff.op)
               OP_RAISE: begin
                  if (nf.used) begin
                     b_act    = rd_act_ff;
                     b_wb     = rd_wb_ff;
                     b_wc     = rd_wc_ff;
                     b_sil    = rd_silent_ff;
                     b_clr    = rd_cleared_ff;
                     b_raised = rd_raised_ff;
                     wd_key   = rd_key_ff;
                  end else begin
                     nf       = '0;
                     nf.used  = 1'b1;
                     b_wb     = cur_ff.req.now;
                     wd_key   = cur_ff.req.alarm_key;
                  end
                  nf.notice  = 1'b0;
                  nf.retired = 1'b0;
                  if (!nf.active) begin
                     newly     = 1'b1;
                     nf.active = 1'b1;
                     nf.acked  = 1'b0;
                     b_raised  = cur_ff.req.now;
                     b_clr     = '0;
                     if (b_act != 16'hFFFF) b_act = b_act + 16'd1;
                     if (later(cur_ff.req.now, b_wb, {1'b0, cfg.chatter_window})) begin
                        b_wb = cur_ff.req.now;
                        b_wc = '0;
                     end
                     if (b_wc != 8'hFF) b_wc = b_wc + 8'd1;
                     if (b_wc >= cfg.chatter_limit && b_sil < cur_ff.req.now)
                        b_sil = add_sat(cur_ff.req.now, cfg.shelf_time);
                  end
                  if (b_sil > cur_ff.req.now) newly = 1'b0;
                  we_all     = 1'b1;
                  wd_sev     = cur_ff.req.severity;
                  wd_raised  = b_raised;
                  wd_cleared = b_clr;
                  wd_act     = b_act;
                  wd_wb      = b_wb;
                  wd_wc      = b_wc;
                  wd_silent  = b_sil;
                  flags_we   = 1'b1;
                  flags_wd   = nf;
                  notify_in  = newly;
                  rtotal_in  = b_act;
                  gen_in     = gen_ff + 32'd1;
               end
               OP_NOTE: begin
                  nf         = '0;
                  nf.used    = 1'b1;
                  nf.notice  = 1'b1;
                  we_all     = 1'b1;
                  wd_key     = cur_ff.req.alarm_key;
                  wd_sev     = cur_ff.req.severity;
                  wd_raised  = cur_ff.req.now;
                  wd_cleared = '0;
                  wd_act     = 16'd1;
                  wd_wb      = '0;
                  wd_wc      = '0;
                  wd_silent  = '0;
                  flags_we   = 1'b1;
                  flags_wd   = nf;
                  rtotal_in  = 16'd1;
                  gen_in     = gen_ff + 32'd1;
               end
               OP_CLEAR: begin
                  if (nf.active) begin
                     nf.active = 1'b0;
                     we_clr    = 1'b1;
                     if (nf.acked || rd_sev_ff < cfg.high_severity) begin
                        nf.retired = 1'b1;
                        nf.acked   = 1'b1;
                     end
                     flags_we = 1'b1;
                     flags_wd = nf;
                     gen_in   = gen_ff + 32'd1;
                  end
                  rtotal_in = rd_act_ff;
               end
               OP_ACK: begin
                  nf.acked = 1'b1;
                  if (!nf.active) begin
                     nf.retired = 1'b1;
                     we_clr     = (rd_cleared_ff == 32'd0);
                  end
                  flags_we  = 1'b1;
                  flags_wd  = nf;
                  rtotal_in = rd_act_ff;
                  gen_in    = gen_ff + 32'd1;
               end
               OP_SHELVE: begin
                  nf.acked  = 1'b1;
                  we_sil    = 1'b1;
                  wd_silent = add_sat(cur_ff.req.now, (cur_ff.req.shelve_seconds != 16'd0) ?
                                      cur_ff.req.shelve_seconds : cfg.shelf_time);
                  flags_we  = 1'b1;
                  flags_wd  = nf;
                  rtotal_in = rd_act_ff;
                  gen_in    = gen_ff + 32'd1;
               end
               default: ;
            endcase
            scan_in  = '0;
            state_in = S_TOTAL;
         end

         S_ACK_ALL: begin
            if (pipe_vld_ff) begin
               wa = pipe_idx_ff;
               if (pf.used && !pf.retired) begin
                  nf = pf;
                  if (!pf.acked) nacked_in = nacked_ff + CW'(1);
                  nf.acked = 1'b1;
                  if (!pf.active) begin
                     nf.retired = 1'b1;
                     we_clr     = (rd_cleared_ff == 32'd0);
                  end
                  flags_we = 1'b1;
                  flags_wd = nf;
               end
            end else if (scan_ff == SCAN_END) begin
               gen_in   = gen_ff + 32'd1;
               scan_in  = '0;
               state_in = S_TOTAL;
            end
         end

         S_TOTAL: begin
            if (pipe_vld_ff) begin
               if (pf.used && !pf.retired) begin
                  if (!pf.acked) begin
                     unacked_in = unacked_ff + CW'(1);
                     if ($signed({1'b0, rd_sev_ff}) > worst_ff)
                        worst_in = $signed({1'b0, rd_sev_ff});
                  end
                  if (pf.active) active_in = active_ff + CW'(1);
               end
            end else if (scan_ff == SCAN_END) begin
               state_in = S_DONE;
            end
         end

         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in         = 1'b1;
               rsp_in.status        = status_ff;
               rsp_in.notify        = notify_ff;
               rsp_in.newly_acked   = 6'(nacked_ff);
               rsp_in.raise_total   = rtotal_ff;
               rsp_in.unacked_total = 6'(unacked_ff);
               rsp_in.active_total  = 6'(active_ff);
               rsp_in.worst_unacked = worst_ff;
               rsp_in.generation    = gen_ff;
               state_in             = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pipe_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         gen_ff       <= '0;
         for (int i = 0; i < TABLE_DEPTH; i++) flags_ff[i] <= '0;
      end else begin
         state_ff     <= state_in;
         pipe_vld_ff  <= pipe_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         gen_ff       <= gen_in;
         if (flags_we) flags_ff[flags_wa] <= flags_wd;
      end
      cur_ff      <= cur_in;
      scan_ff     <= scan_in;
      pipe_idx_ff <= pipe_idx_in;
      hit_ff      <= hit_in;
      hit_idx_ff  <= hit_idx_in;
      free_ff     <= free_in;
      free_idx_ff <= free_idx_in;
      ret_ff      <= ret_in;
      ret_idx_ff  <= ret_idx_in;
      old_ff      <= old_in;
      old_idx_ff  <= old_idx_in;
      old_time_ff <= old_time_in;
      slot_ff     <= slot_in;
      nacked_ff   <= nacked_in;
      unacked_ff  <= unacked_in;
      active_ff   <= active_in;
      worst_ff    <= worst_in;
      status_ff   <= status_in;
      notify_ff   <= notify_in;
      rtotal_ff   <= rtotal_in;
      rsp_ff      <= rsp_in;
   end

endmodule

@@ rtl/alarm_table_with_chatter_shelving.sv @@
// ----------------------------------------------------------------------------
// alarm_table_with_chatter_shelving
// Keyed alarm table with ack, chatter shelving and eviction.
// ----------------------------------------------------------------------------
// In the back end a command is taken in the idle state; a lookup scan then
// reads one entry per cycle from the entry memories (key match, reaping,
// free slot and eviction choice together), followed by a read state and an
// update state on the chosen entry, then a totals scan, again one entry per
// cycle through the same single read port. Each scan ends with the registered
// read of its last entry and a decision step, and the done state loads the
// response register once it is free. Ack all replaces lookup and update with
// one sweep; an unknown command runs the totals scan only, and a lookup that
// yields no entry goes straight to the totals scan. A two-deep request queue
// lets the next command transfer in while one is in work, and the response
// register holds a finished result until its transfer.
// The per-entry marks live in flops cleared by reset, so there is no clearing
// pass; the other entry fields are only read after being written.
// ----------------------------------------------------------------------------
module alarm_table_with_chatter_shelving import atcs_pkg::*; #(
   parameter int TABLE_DEPTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   cfg_type  cfg_ff;
   logic     q_valid, q_ready;
   work_type q_item;

   // configuration registers; the user must write them only while quiet, unchecked
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.chatter_limit  <= 8'd5;
         cfg_ff.chatter_window <= 16'd600;
         cfg_ff.shelf_time     <= 16'd1800;
         cfg_ff.high_severity  <= 3'd2;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_CHATTER_LIMIT:  cfg_ff.chatter_limit  <= csr_wdata[7:0];
            CSR_CHATTER_WINDOW: cfg_ff.chatter_window <= csr_wdata;
            CSR_SHELF_TIME:     cfg_ff.shelf_time     <= csr_wdata;
            CSR_HIGH_SEVERITY:  cfg_ff.high_severity  <= csr_wdata[2:0];
            default: ;
         endcase
      end
   end

   // front: decode and queue
   atcs_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_valid   (q_valid),
      .q_ready   (q_ready),
      .q_item    (q_item)
   );

   // back: table scans, entry update, response
   atcs_back #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_valid   (q_valid),
      .q_ready   (q_ready),
      .q_item    (q_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

@@ test/alarm_table_with_chatter_shelving_tb.sv @@
// ----------------------------------------------------------------------------
// alarm_table_with_chatter_shelving_tb
// Self-checking bench for the alarm table. A scoreboard class keeps its own
// copy of the table and the registers, predicts one response per accepted
// request and checks responses field by field, in order. Stimulus is a short
// directed run followed by random command streams over a small key pool, in
// phases with different register settings and idling patterns.
// ----------------------------------------------------------------------------
module alarm_table_with_chatter_shelving_tb;
   import atcs_pkg::*;

   localparam int DEPTH = 32;

   // -------------------------------------------------------------------------
   // Scoreboard: shadow table, register copy and queue of predicted responses
   // -------------------------------------------------------------------------
   class alarm_scoreboard;
      flags_type   flg[DEPTH];
      logic [15:0] key_mem[DEPTH];
      logic [2:0]  sev_mem[DEPTH];
      logic [7:0]  sink_mem[DEPTH];
      logic [31:0] raised_at[DEPTH];
      logic [31:0] cleared_at[DEPTH];
      logic [15:0] acts[DEPTH];
      logic [31:0] win_begin[DEPTH];
      logic [7:0]  win_cnt[DEPTH];
      logic [31:0] silent[DEPTH];
      logic [31:0] gen;
      cfg_type     cfg;
      rsp_type     pending[$];
      int          fails;

      function new();
         for (int i = 0; i < DEPTH; i++) wipe(i);
         gen = 0;
         fails = 0;
         cfg.chatter_limit  = 8'd5;
         cfg.chatter_window = 16'd600;
         cfg.shelf_time     = 16'd1800;
         cfg.high_severity  = 3'd2;
      endfunction

      function void wipe(int i);
         flg[i] = '0; key_mem[i] = 0; sev_mem[i] = 0; sink_mem[i] = 0;
         raised_at[i] = 0; cleared_at[i] = 0; acts[i] = 0;
         win_begin[i] = 0; win_cnt[i] = 0; silent[i] = 0;
      endfunction

      function void write_reg(logic [1:0] idx, logic [15:0] d);
         case (idx)
            CSR_CHATTER_LIMIT:  cfg.chatter_limit  = d[7:0];
            CSR_CHATTER_WINDOW: cfg.chatter_window = d;
            CSR_SHELF_TIME:     cfg.shelf_time     = d;
            CSR_HIGH_SEVERITY:  cfg.high_severity  = d[2:0];
            default: ;
         endcase
      endfunction

      // signed difference, so a clock running backwards never counts as elapsed
      function longint since(logic [31:0] t1, logic [31:0] t0);
         return longint'(t1) - longint'(t0);
      endfunction

      function logic [31:0] until_sat(logic [31:0] t, logic [15:0] d);
         longint s;
         s = longint'(t) + longint'(d);
         return (s > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : s[31:0];
      endfunction

      function int find_key(logic [15:0] k);
         for (int i = 0; i < DEPTH; i++)
            if (flg[i].used && key_mem[i] == k) return i;
         return -1;
      endfunction

      // match, else free slot, else first retired, else oldest acked inactive
      function int pick_slot(logic [15:0] k);
         int a;
         int oldest;
         a = find_key(k);
         if (a >= 0) return a;
         for (int i = 0; i < DEPTH; i++)
            if (!flg[i].used) return i;
         oldest = -1;
         for (int i = 0; i < DEPTH; i++) begin
            if (flg[i].retired) return i;
            if (flg[i].active || !flg[i].acked) continue;
            if (oldest < 0 || raised_at[i] < raised_at[oldest]) oldest = i;
         end
         return oldest;
      endfunction

      function void reap(logic [31:0] t);
         for (int i = 0; i < DEPTH; i++)
            if (flg[i].used && flg[i].retired &&
                since(t, cleared_at[i]) > 2 * longint'(cfg.chatter_window) &&
                silent[i] < t)
               wipe(i);
      endfunction

      function void ack_one(int i, logic [31:0] t);
         flg[i].acked = 1'b1;
         if (!flg[i].active) begin
            flg[i].retired = 1'b1;
            if (cleared_at[i] == 0) cleared_at[i] = t;
         end
      endfunction

      function rsp_type predict(req_type r);
         rsp_type o;
         int      a;
         int      worst;
         bit      fresh;
         o = '0;
         worst = -1;
         case (r.cmd)
            CMD_RAISE: begin
               reap(r.now);
               a = pick_slot(r.alarm_key);
               if (a < 0) o.status = ST_FULL;
               else begin
                  if (!flg[a].used) begin
                     wipe(a);
                     flg[a].used = 1'b1;
                     key_mem[a] = r.alarm_key;
                     win_begin[a] = r.now;
                  end
                  sev_mem[a] = r.severity;
                  sink_mem[a] = r.sink_mask;
                  flg[a].notice = 1'b0;
                  flg[a].retired = 1'b0;
                  fresh = 0;
                  if (!flg[a].active) begin
                     fresh = 1;
                     flg[a].active = 1'b1;
                     flg[a].acked = 1'b0;
                     raised_at[a] = r.now;
                     cleared_at[a] = 0;
                     if (acts[a] != 16'hFFFF) acts[a]++;
                     if (since(r.now, win_begin[a]) > longint'(cfg.chatter_window)) begin
                        win_begin[a] = r.now;
                        win_cnt[a] = 0;
                     end
                     if (win_cnt[a] != 8'hFF) win_cnt[a]++;
                     if (win_cnt[a] >= cfg.chatter_limit && silent[a] < r.now)
                        silent[a] = until_sat(r.now, cfg.shelf_time);
                  end
                  if (silent[a] > r.now) fresh = 0;
                  o.notify = fresh;
                  o.raise_total = acts[a];
                  gen++;
               end
            end
            CMD_CLEAR: begin
               a = find_key(r.alarm_key);
               if (a < 0) o.status = ST_NOT_FOUND;
               else begin
                  if (flg[a].active) begin
                     flg[a].active = 1'b0;
                     cleared_at[a] = r.now;
                     if (flg[a].acked || sev_mem[a] < cfg.high_severity) begin
                        flg[a].retired = 1'b1;
                        flg[a].acked = 1'b1;
                     end
                     gen++;
                  end
                  o.raise_total = acts[a];
               end
            end
            CMD_NOTE: begin
               a = pick_slot(r.alarm_key);
               if (a < 0) o.status = ST_FULL;
               else begin
                  wipe(a);
                  flg[a].used = 1'b1;
                  flg[a].notice = 1'b1;
                  key_mem[a] = r.alarm_key;
                  raised_at[a] = r.now;
                  sev_mem[a] = r.severity;
                  sink_mem[a] = r.sink_mask;
                  acts[a] = 1;
                  o.raise_total = 1;
                  gen++;
               end
            end
            CMD_ACK: begin
               a = find_key(r.alarm_key);
               if (a < 0) o.status = ST_NOT_FOUND;
               else begin
                  ack_one(a, r.now);
                  o.raise_total = acts[a];
                  gen++;
               end
            end
            CMD_ACK_ALL: begin
               for (int i = 0; i < DEPTH; i++) begin
                  if (!flg[i].used || flg[i].retired) continue;
                  if (!flg[i].acked) o.newly_acked++;
                  ack_one(i, r.now);
               end
               gen++;
            end
            CMD_SHELVE: begin
               a = find_key(r.alarm_key);
               if (a < 0) o.status = ST_NOT_FOUND;
               else begin
                  silent[a] = until_sat(r.now, (r.shelve_seconds != 0) ?
                                        r.shelve_seconds : cfg.shelf_time);
                  flg[a].acked = 1'b1;
                  o.raise_total = acts[a];
                  gen++;
               end
            end
            default: ;
         endcase
         // totals over listed entries
         for (int i = 0; i < DEPTH; i++) begin
            if (!flg[i].used || flg[i].retired) continue;
            if (!flg[i].acked) begin
               o.unacked_total++;
               if (int'(sev_mem[i]) > worst) worst = sev_mem[i];
            end
            if (flg[i].active) o.active_total++;
         end
         o.worst_unacked = worst[3:0];
         o.generation = gen;
         return o;
      endfunction

      function void note_request(req_type r);
         pending.push_back(predict(r));
      endfunction

      task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
         $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
         fails++;
      endtask

      task check_response(rsp_type got);
         rsp_type want;
         if (pending.size() == 0) begin
            report_mismatch("response with none pending", 0, 0);
            return;
         end
         want = pending.pop_front();
         if (got.status != want.status)
            report_mismatch("status", got.status, want.status);
         if (got.notify != want.notify)
            report_mismatch("notify", got.notify, want.notify);
         if (got.newly_acked != want.newly_acked)
            report_mismatch("newly_acked", got.newly_acked, want.newly_acked);
         if (got.raise_total != want.raise_total)
            report_mismatch("raise_total", got.raise_total, want.raise_total);
         if (got.unacked_total != want.unacked_total)
            report_mismatch("unacked_total", got.unacked_total, want.unacked_total);
         if (got.active_total != want.active_total)
            report_mismatch("active_total", got.active_total, want.active_total);
         if (got.worst_unacked !== want.worst_unacked)
            report_mismatch("worst_unacked", got.worst_unacked, want.worst_unacked);
         if (got.generation != want.generation)
            report_mismatch("generation", got.generation, want.generation);
      endtask
   endclass

   // -------------------------------------------------------------------------
   // DUT hookup; every input starts at a known value
   // -------------------------------------------------------------------------
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [15:0] csr_wdata = '0;

   alarm_table_with_chatter_shelving dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   alarm_scoreboard sb = new();

   int          send_idle_pct = 0;   // chance per cycle the sender holds off
   int          recv_stall_pct = 0;  // chance per cycle the receiver stalls
   logic [31:0] t_now = 32'd1000;    // running wall time for random traffic

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // hard stop in case the block hangs
   initial begin
      #5000000;
      $display("FAIL");
      $finish;
   end

   // Receiver: random stalls, and the response check. Values sampled here are
   // the ones from before this edge, since everything is driven with NBAs.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_response(rsp_data);
      rsp_ready <= !reset && ($urandom_range(99) >= recv_stall_pct);
   end

   // -------------------------------------------------------------------------
   // Drivers
   // -------------------------------------------------------------------------

   // one request transfer, then an optional idle gap (never zero length, so
   // valid is not dropped and raised in the same step)
   task automatic send(req_type r);
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
      sb.note_request(r);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      @(posedge clock);
   endtask

   // register write; only called with the table drained
   task automatic csr_write(logic [1:0] idx, logic [15:0] d);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= d;
      @(posedge clock);
      sb.write_reg(idx, d);
   endtask

   task automatic configure(logic [7:0] lim, logic [15:0] win, logic [15:0] shelf,
                            logic [2:0] hsev);
      drain();
      csr_write(CSR_CHATTER_LIMIT, {8'd0, lim});
      csr_write(CSR_CHATTER_WINDOW, win);
      csr_write(CSR_SHELF_TIME, shelf);
      csr_write(CSR_HIGH_SEVERITY, {13'd0, hsev});
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   function automatic req_type mk(logic [2:0] c, logic [15:0] k, logic [31:0] t,
                                  logic [2:0] s, logic [7:0] m, logic [15:0] secs);
      req_type r;
      r.cmd = c; r.alarm_key = k; r.now = t;
      r.severity = s; r.sink_mask = m; r.shelve_seconds = secs;
      return r;
   endfunction

   // Random traffic. Keys mostly come from a pool a bit larger than the table
   // so it fills and evicts; time mostly creeps forward in steps scaled to the
   // chatter window, with rare big jumps, backward steps and near-wrap values.
   task automatic run_random(int n);
      req_type     r;
      int          pick;
      int          span;
      logic [15:0] k;
      for (int j = 0; j < n; j++) begin
         span = sb.cfg.chatter_window / 4 + 2;
         pick = $urandom_range(99);
         if (pick < 3)       t_now = $urandom;
         else if (pick < 6)  t_now = 32'hFFFF_FF00 + $urandom_range(255);
         else if (pick < 10) t_now = t_now - $urandom_range(span);
         else if (pick < 16) t_now = t_now + 3 * sb.cfg.chatter_window + $urandom_range(span);
         else                t_now = t_now + $urandom_range(span);
         k = ($urandom_range(99) < 88) ? 16'($urandom_range(39)) : 16'($urandom);
         pick = $urandom_range(99);
         r = mk(CMD_RAISE, k, t_now, 3'($urandom), 8'($urandom),
                ($urandom_range(3) == 0) ? 16'd0 : 16'($urandom));
         if (pick < 36)      r.cmd = CMD_RAISE;
         else if (pick < 58) r.cmd = CMD_CLEAR;
         else if (pick < 68) r.cmd = CMD_NOTE;
         else if (pick < 83) r.cmd = CMD_ACK;
         else if (pick < 86) r.cmd = CMD_ACK_ALL;
         else if (pick < 96) r.cmd = CMD_SHELVE;
         else                r.cmd = 3'($urandom_range(6, 7));  // codes with no command
         send(r);
      end
   endtask

   // -------------------------------------------------------------------------
   // Test sequence
   // -------------------------------------------------------------------------
   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: field extremes, every command, not-found and unknown codes,
      // clear of an inactive alarm, saturating shelve, chatter shelving
      send(mk(CMD_RAISE,   16'h0000, 32'd0,         3'd7, 8'hFF, 16'd0));
      send(mk(CMD_RAISE,   16'hFFFF, 32'hFFFF_FFFF, 3'd0, 8'h00, 16'hFFFF));
      send(mk(CMD_RAISE,   16'h0000, 32'd5,         3'd3, 8'h5A, 16'd0));
      send(mk(CMD_CLEAR,   16'h0000, 32'd10,        3'd0, 8'h00, 16'd0));
      send(mk(CMD_CLEAR,   16'h0000, 32'd11,        3'd0, 8'h00, 16'd0));
      send(mk(CMD_CLEAR,   16'h1234, 32'd12,        3'd0, 8'h00, 16'd0));
      send(mk(CMD_ACK,     16'hFFFF, 32'd13,        3'd0, 8'h00, 16'd0));
      send(mk(CMD_ACK,     16'h4321, 32'd14,        3'd0, 8'h00, 16'd0));
      send(mk(CMD_NOTE,    16'h0007, 32'd15,        3'd6, 8'hA5, 16'd0));
      send(mk(CMD_NOTE,    16'h0007, 32'd16,        3'd1, 8'h3C, 16'd0));
      send(mk(CMD_SHELVE,  16'h0000, 32'd17,        3'd0, 8'h00, 16'd0));
      send(mk(CMD_SHELVE,  16'hFFFF, 32'hFFFF_FFF0, 3'd0, 8'h00, 16'hFFFF));
      send(mk(CMD_SHELVE,  16'hBEEF, 32'd18,        3'd0, 8'h00, 16'd9));
      send(mk(CMD_ACK_ALL, 16'h0000, 32'd19,        3'd0, 8'h00, 16'd0));
      send(mk(3'd6,        16'h0001, 32'd20,        3'd0, 8'h00, 16'd0));
      send(mk(3'd7,        16'h0002, 32'd21,        3'd0, 8'h00, 16'd0));
      // rapid raise and clear of one key trips the default chatter limit
      for (int j = 0; j < 5; j++) begin
         send(mk(CMD_RAISE, 16'h0005, 32'd100 + j, 3'd4, 8'h01, 16'd0));
         send(mk(CMD_CLEAR, 16'h0005, 32'd100 + j, 3'd0, 8'h00, 16'd0));
      end

      // phase 0: defaults, no idling
      run_random(106);

      // phase 1: small settings, sender mostly idle
      configure(8'd1, 16'd1, 16'd1, 3'd0);
      send_idle_pct = 82; recv_stall_pct = 0;
      run_random(106);

      // phase 2: largest settings, receiver mostly stalled
      configure(8'd255, 16'd65535, 16'd65535, 3'd7);
      send_idle_pct = 0; recv_stall_pct = 82;
      run_random(106);

      // phase 3: zero chatter limit (every activation shelves), light idling
      configure(8'd0, 16'd30, 16'd45, 3'd3);
      send_idle_pct = 25; recv_stall_pct = 25;
      run_random(106);

      // phase 4: tight window so reaping and eviction happen often, no idling
      configure(8'd3, 16'd10, 16'd20, 3'd2);
      send_idle_pct = 0; recv_stall_pct = 0;
      run_random(106);

      // wait out the last responses, then idle before the final verdict
      drain();
      repeat (100) @(posedge clock);
      if (sb.fails == 0 && sb.pending.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/atcs_pkg.sv
rtl/atcs_front.sv
rtl/atcs_back.sv
rtl/alarm_table_with_chatter_shelving.sv
test/alarm_table_with_chatter_shelving_tb.sv
